// ===== sv/mbfa_pkg.sv =====
// Shared types, constants and the reciprocal table for the frame accumulator.
package mbfa_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CHAN_W    = 8;
  localparam int BLUR_W    = 7;
  localparam int DIM_W     = 11;
  localparam int PHASE_W   = 6;
  localparam int RECIP_W   = 17;
  localparam int RECIP_SH  = 16;
  localparam int BLUR_MAX  = 64;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int JOBQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 4;

  localparam logic [BLUR_W-1:0] BLUR_RST   = 7'd1;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd1024;

  typedef enum logic [1:0] {
    REG_BLUR   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [BLUR_W-1:0] blur;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } cfg_t;

  // per-pixel job handed from front to back (address travels alongside)
  typedef struct packed {
    logic [CHAN_W-1:0] qb;
    logic [CHAN_W-1:0] qg;
    logic [CHAN_W-1:0] qr;
    logic              first;
    logic              last;
    logic              fend;
  } job_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              frame_end;
  } res_t;

  // ceil(2^16 / n) for n = 1..64; floor(v * m >> 16) == floor(v / n) for any 8-bit v
  localparam logic [RECIP_W-1:0] RECIP_TABLE [BLUR_MAX] = '{
    17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923, 17'd9363, 17'd8192,
    17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,  17'd4370, 17'd4096,
    17'd3856,  17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850, 17'd2731,
    17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,  17'd2185,  17'd2115, 17'd2048,
    17'd1986,  17'd1928,  17'd1873,  17'd1821,  17'd1772,  17'd1725,  17'd1681, 17'd1639,
    17'd1599,  17'd1561,  17'd1525,  17'd1490,  17'd1457,  17'd1425,  17'd1395, 17'd1366,
    17'd1338,  17'd1311,  17'd1286,  17'd1261,  17'd1237,  17'd1214,  17'd1192, 17'd1171,
    17'd1150,  17'd1130,  17'd1111,  17'd1093,  17'd1075,  17'd1058,  17'd1041, 17'd1024
  };

  // n must already be limited to 1..64
  function automatic logic [RECIP_W-1:0] recip(input logic [BLUR_W-1:0] n);
    logic [PHASE_W-1:0] idx;
    idx = PHASE_W'(n - BLUR_W'(1));
    return RECIP_TABLE[idx];
  endfunction

  function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
  endfunction

endpackage

// ===== sv/motion_blur_frame_accumulator.sv =====
// Top level of the temporal frame averager: register port, front, job queue, back, result queue.
//
// Pixels enter in raster order through the push side and are averaged over groups of
// blur_factor frames; on the last frame of a group each pixel leaves as BGR with frame_end
// on the frame's final pixel. The front takes one pixel per clock while its two pipeline
// stages and the four-entry job queue together hold fewer than four pixels; the back takes a
// new pixel only when idle, since the single-port accumulation store (MAX_WIDTH*MAX_HEIGHT
// words of 24 bits) is read as a pixel is taken and written back in the next cycle. A pixel
// passes the front's two registers and the job queue, and on a group's last frame its result
// enters the result queue as the back writes the entry back. The store is not cleared after
// reset: the first frame of each group writes every entry before it is read, and the block
// accepts pixels straight out of reset. Registers: blur_factor at 0x0, frame_width at 0x4,
// frame_height at 0x8; change them only while no pixel is in flight.
module motion_blur_frame_accumulator
  import mbfa_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic              pop,
  output logic              empty,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_red,
  output logic              frame_end
);

  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int QCW = $clog2(JOBQ_DEPTH + 1);
  localparam int OCW = $clog2(RESQ_DEPTH + 1);
  localparam int JW  = AW + $bits(job_t);
  localparam int RSW = $bits(res_t);

  cfg_t           cfg;
  reg_idx_t       reg_idx;
  logic           cfg_wr;

  logic           q_wr_en;
  logic [AW-1:0]  f_addr;
  job_t           f_job;
  logic           q_rd_en;
  logic [JW-1:0]  q_data;
  logic [QCW-1:0] q_count;
  logic [AW-1:0]  b_addr;
  job_t           b_job;

  logic           o_wr_en;
  res_t           o_res_in;
  res_t           o_res_out;
  logic [OCW-1:0] o_count;
  logic           o_rd_en;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blur   <= BLUR_RST;
      cfg.width  <= WIDTH_RST;
      cfg.height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BLUR:   cfg.blur   <= pwdata[BLUR_W-1:0];
        REG_WIDTH:  cfg.width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[DIM_W-1:0];
        default:    cfg        <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLUR:   prdata = APB_DW'(cfg.blur);
      REG_WIDTH:  prdata = APB_DW'(cfg.width);
      REG_HEIGHT: prdata = APB_DW'(cfg.height);
      default:    prdata = '0;
    endcase
  end

  mbfa_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .QDEPTH     (JOBQ_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .full    (full),
    .q_count (q_count),
    .q_wr_en (q_wr_en),
    .q_addr  (f_addr),
    .q_job   (f_job)
  );

  mbfa_fifo #(
    .WIDTH (JW),
    .DEPTH (JOBQ_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data ({f_addr, f_job}),
    .rd_en   (q_rd_en),
    .rd_data (q_data),
    .count   (q_count)
  );

  assign b_addr = q_data[JW-1 -: AW];
  assign b_job  = job_t'(q_data[$bits(job_t)-1:0]);

  mbfa_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .QDEPTH     (JOBQ_DEPTH),
    .ODEPTH     (RESQ_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_count (q_count),
    .q_addr  (b_addr),
    .q_job   (b_job),
    .q_rd_en (q_rd_en),
    .o_count (o_count),
    .o_wr_en (o_wr_en),
    .o_res   (o_res_in)
  );

  logic [RSW-1:0] o_data;

  mbfa_fifo #(
    .WIDTH (RSW),
    .DEPTH (RESQ_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (o_wr_en),
    .wr_data (o_res_in),
    .rd_en   (o_rd_en),
    .rd_data (o_data),
    .count   (o_count)
  );

  assign o_res_out = res_t'(o_data);
  assign empty     = (o_count == '0);
  assign o_rd_en   = pop && !empty;
  assign out_blue  = o_res_out.blue;
  assign out_green = o_res_out.green;
  assign out_red   = o_res_out.red;
  assign frame_end = o_res_out.frame_end;

endmodule

// ===== sv/mbfa_fifo.sv =====
// Small first-in first-out queue used between the block's stages.
module mbfa_fifo
  import mbfa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  assign rd_data = slots[rd_ptr];
  assign count   = fill;

endmodule

// ===== sv/mbfa_front.sv =====
// Front end: pixel acceptance, raster counters, store address and per-channel division.
module mbfa_front
  import mbfa_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int QDEPTH     = JOBQ_DEPTH,
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int QCW = $clog2(QDEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              push,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              full,
  input  logic [QCW-1:0]    q_count,
  output logic              q_wr_en,
  output logic [AW-1:0]     q_addr,
  output job_t              q_job
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int DW0 = (CW > RW) ? CW + 1 : RW + 1;
  localparam int DW  = (DW0 > DIM_W) ? DW0 : DIM_W;
  localparam int PW  = RECIP_W + CHAN_W;

  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [PHASE_W-1:0] phase;

  logic [BLUR_W-1:0]  n_eff;
  logic [DW-1:0]      w_eff;
  logic [DW-1:0]      h_eff;
  logic               accept;
  logic               last_frame;
  logic               line_end;
  logic               frame_end;
  logic [QCW:0]       in_flight;

  logic               a_valid;
  logic [CHAN_W-1:0]  a_r;
  logic [CHAN_W-1:0]  a_g;
  logic [CHAN_W-1:0]  a_b;
  logic [RECIP_W-1:0] a_recip;
  logic [AW-1:0]      a_addr;
  logic               a_first;
  logic               a_last;
  logic               a_fend;

  logic               b_valid;
  logic [AW-1:0]      b_addr;
  job_t               b_job;

  logic [PW-1:0]      prod_r;
  logic [PW-1:0]      prod_g;
  logic [PW-1:0]      prod_b;

  always_comb begin
    if (cfg.blur == '0)                        n_eff = BLUR_W'(1);
    else if (cfg.blur > BLUR_W'(BLUR_MAX))     n_eff = BLUR_W'(BLUR_MAX);
    else                                       n_eff = cfg.blur;

    if (cfg.width == '0)                       w_eff = DW'(1);
    else if (DW'(cfg.width) > DW'(MAX_WIDTH))  w_eff = DW'(MAX_WIDTH);
    else                                       w_eff = DW'(cfg.width);

    if (cfg.height == '0)                      h_eff = DW'(1);
    else if (DW'(cfg.height) > DW'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
    else                                       h_eff = DW'(cfg.height);
  end

  assign last_frame = (BLUR_W'(phase) + BLUR_W'(1)) >= n_eff;
  assign line_end   = (DW'(col) + DW'(1)) >= w_eff;
  assign frame_end  = line_end && ((DW'(row) + DW'(1)) >= h_eff);

  // items already past the push handshake but not yet in the queue count against it
  assign in_flight = (QCW+1)'(q_count) + (QCW+1)'(a_valid) + (QCW+1)'(b_valid);
  assign full      = in_flight >= (QCW+1)'(QDEPTH);
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      phase   <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      if (accept) begin
        if (line_end) begin
          col <= '0;
          if (frame_end) begin
            row   <= '0;
            phase <= last_frame ? '0 : phase + PHASE_W'(1);
          end else begin
            row <= row + RW'(1);
          end
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r     <= red;
      a_g     <= green;
      a_b     <= blue;
      a_recip <= recip(n_eff);
      a_addr  <= AW'(row) * AW'(MAX_WIDTH) + AW'(col);
      a_first <= (phase == '0);
      a_last  <= last_frame;
      a_fend  <= frame_end;
    end
  end

  assign prod_r = PW'(a_r) * PW'(a_recip);
  assign prod_g = PW'(a_g) * PW'(a_recip);
  assign prod_b = PW'(a_b) * PW'(a_recip);

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_addr      <= a_addr;
      b_job.qr    <= prod_r[RECIP_SH +: CHAN_W];
      b_job.qg    <= prod_g[RECIP_SH +: CHAN_W];
      b_job.qb    <= prod_b[RECIP_SH +: CHAN_W];
      b_job.first <= a_first;
      b_job.last  <= a_last;
      b_job.fend  <= a_fend;
    end
  end

  assign q_wr_en = b_valid;
  assign q_addr  = b_addr;
  assign q_job   = b_job;

endmodule

// ===== sv/mbfa_back.sv =====
// Back end: accumulation store read-modify-write and result generation.
module mbfa_back
  import mbfa_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int QDEPTH     = JOBQ_DEPTH,
  parameter int ODEPTH     = RESQ_DEPTH,
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int QCW = $clog2(QDEPTH + 1),
  localparam int OCW = $clog2(ODEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [QCW-1:0] q_count,
  input  logic [AW-1:0]  q_addr,
  input  job_t           q_job,
  output logic           q_rd_en,
  input  logic [OCW-1:0] o_count,
  output logic           o_wr_en,
  output res_t           o_res
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int EW    = 3 * CHAN_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              start;
  logic [AW-1:0]     w_addr;
  job_t              w_job;
  logic [EW-1:0]     rdata;
  logic [CHAN_W-1:0] sum_r;
  logic [CHAN_W-1:0] sum_g;
  logic [CHAN_W-1:0] sum_b;

  // entry layout {red, green, blue}
  logic [EW-1:0] store [DEPTH];

  // one item in flight at most, so in idle an output slot is free when the count says so
  assign start = (state == ST_IDLE) && (q_count != '0) && (o_count < OCW'(ODEPTH));

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = start ? ST_CALC : ST_IDLE;
      ST_CALC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_addr <= q_addr;
      w_job  <= q_job;
    end
  end

  // read issued on the pop cycle, written back the cycle after
  always_ff @(posedge clk) begin
    if (start) rdata <= store[q_addr];
    if (state == ST_CALC) store[w_addr] <= {sum_r, sum_g, sum_b};
  end

  always_comb begin
    if (w_job.first) begin
      sum_r = w_job.qr;
      sum_g = w_job.qg;
      sum_b = w_job.qb;
    end else begin
      sum_r = sat_add(rdata[2*CHAN_W +: CHAN_W], w_job.qr);
      sum_g = sat_add(rdata[CHAN_W +: CHAN_W], w_job.qg);
      sum_b = sat_add(rdata[0 +: CHAN_W], w_job.qb);
    end
  end

  assign q_rd_en         = start;
  assign o_wr_en         = (state == ST_CALC) && w_job.last;
  assign o_res.red       = sum_r;
  assign o_res.green     = sum_g;
  assign o_res.blue      = sum_b;
  assign o_res.frame_end = w_job.fend;

endmodule

// ===== sv/mbfa_checker.sv =====
// Port-level checks for the frame accumulator, bound to the top level.
module mbfa_checker
  import mbfa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input logic [CHAN_W-1:0] out_blue,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_red,
  input logic              frame_end,
  input logic              pready
);

  // nothing survives a reset on the result side
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // both queues are drained by reset, so pixels are taken straight away
  a_rst_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready deasserted");

  // a waiting result holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_blue) && $stable(out_green)
                          && $stable(out_red) && $stable(frame_end)))
    else $error("waiting result changed before transfer");

endmodule

bind motion_blur_frame_accumulator mbfa_checker u_checker (.*);

// ===== tb/motion_blur_frame_accumulator_test.sv =====
// Testbench for the motion blur frame accumulator: checks averaged BGR output against a predictor.
`timescale 1ns / 100ps

module motion_blur_frame_accumulator_test
  import mbfa_pkg::*;
();

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int MAX_H         = MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 2000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_PATTERN} pop_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              push = 1'b0;
  logic              full;
  logic [CHAN_W-1:0] red = '0;
  logic [CHAN_W-1:0] green = '0;
  logic [CHAN_W-1:0] blue = '0;
  logic              pop = 1'b0;
  logic              empty;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_red;
  logic              frame_end;

  motion_blur_frame_accumulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .push      (push),
    .full      (full),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .pop       (pop),
    .empty     (empty),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .frame_end (frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register mirror
  logic [BLUR_W-1:0] cfg_blur   = BLUR_RST;
  logic [DIM_W-1:0]  cfg_width  = WIDTH_RST;
  logic [DIM_W-1:0]  cfg_height = HEIGHT_RST;
  int                column_pos = 0;
  int                row_pos    = 0;
  int                group_phase = 0;
  logic [23:0]       pixel_sum [int];

  pixel_t pixel_queue [$];
  res_t   averaged_pixels [$];
  int     queued_count = 0;
  int     accepted_count = 0;
  int     mismatch_count = 0;
  bit     in_taken = 1'b0;
  bit     hold_request = 1'b0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int eff_limit(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] sat8(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 9'd255) ? 8'hFF : s[CHAN_W-1:0];
  endfunction

  // one accepted pixel: fold into the running sum, expect output on a group's last frame
  task automatic fold_pixel(pixel_t px);
    int n, w, h, addr;
    logic [CHAN_W-1:0] qr, qg, qb, sr, sg, sb;
    logic [23:0] entry;
    bit last, line_end, fend;
    n = eff_limit(cfg_blur, BLUR_MAX);
    w = eff_limit(cfg_width, MAX_W);
    h = eff_limit(cfg_height, MAX_H);
    qr = CHAN_W'(px.red / n);
    qg = CHAN_W'(px.green / n);
    qb = CHAN_W'(px.blue / n);
    addr = row_pos * MAX_W + column_pos;
    last = (group_phase + 1 >= n);
    line_end = (column_pos + 1 >= w);
    fend = line_end && (row_pos + 1 >= h);
    if (group_phase == 0) begin
      sb = qb;
      sg = qg;
      sr = qr;
    end else begin
      if (!pixel_sum.exists(addr)) begin
        report_mismatch("stimulus read an unwritten sum entry", addr, addr);
        entry = '0;
      end else begin
        entry = pixel_sum[addr];
      end
      sb = sat8(entry[7:0], qb);
      sg = sat8(entry[15:8], qg);
      sr = sat8(entry[23:16], qr);
    end
    pixel_sum[addr] = {sr, sg, sb};
    if (last) averaged_pixels.push_back('{blue: sb, green: sg, red: sr, frame_end: fend});
    if (line_end) begin
      column_pos = 0;
      if (fend) begin
        row_pos = 0;
        group_phase = last ? 0 : group_phase + 1;
      end else begin
        row_pos++;
      end
    end else begin
      column_pos++;
    end
  endtask

  // monitor: result check first, then input transfer prediction
  always @(posedge clk) begin : watch_ports
    res_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (averaged_pixels.size() == 0) begin
          report_mismatch("result with nothing awaited",
                          {out_blue, out_green, out_red, frame_end}, 0);
        end else begin
          want = averaged_pixels.pop_front();
          if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
          if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
          if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
          if (frame_end !== want.frame_end)
            report_mismatch("frame_end", frame_end, want.frame_end);
        end
      end
      in_taken = push && !full;
      if (in_taken) begin
        fold_pixel('{red: red, green: green, blue: blue});
        accepted_count++;
      end
    end
  end

  // pixel driver: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin : drive_pixels
    pixel_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (push && !in_taken) begin
      // transfer still pending, hold the item
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      push <= 1'b0;
    end else if (pixel_queue.size() != 0) begin
      nxt = pixel_queue.pop_front();
      push <= 1'b1;
      red <= nxt.red;
      green <= nxt.green;
      blue <= nxt.blue;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      push <= 1'b0;
    end
  end

  // result receiver: switches between stall patterns, plus one long hold-off
  pop_mode_t  pop_mode = POP_ALWAYS;
  int         mode_left = 64;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  logic [1:0] pop_tick = '0;

  always @(negedge clk) begin
    pop_tick <= pop_tick + 2'd1;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode <= pop_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      unique case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_RANDOM: pop <= 1'($urandom_range(0, 1));
        default:    pop <= (pop_tick != 2'b11);
      endcase
    end
  end

  // register port
  task automatic apb_cycle(reg_idx_t idx, bit wr, logic [APB_DW-1:0] wdata,
                           output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(reg_idx_t idx);
    logic [APB_DW-1:0] got, want;
    unique case (idx)
      REG_BLUR:  want = APB_DW'(cfg_blur);
      REG_WIDTH: want = APB_DW'(cfg_width);
      default:   want = APB_DW'(cfg_height);
    endcase
    apb_cycle(idx, 1'b0, '0, got);
    if (got !== want) report_mismatch("register read-back", got, want);
  endtask

  task automatic program_reg(reg_idx_t idx, int unsigned value);
    logic [APB_DW-1:0] wdata, unused;
    int fw;
    fw = (idx == REG_BLUR) ? BLUR_W : DIM_W;
    // junk above the field now and then; the register keeps only its own bits
    wdata = value | (($urandom_range(0, 3) == 0) ? ($urandom() << fw) : 0);
    apb_cycle(idx, 1'b1, wdata, unused);
    unique case (idx)
      REG_BLUR:  cfg_blur = wdata[BLUR_W-1:0];
      REG_WIDTH: cfg_width = wdata[DIM_W-1:0];
      default:   cfg_height = wdata[DIM_W-1:0];
    endcase
    check_reg(idx);
  endtask

  function automatic int pixels_to_group_end();
    int n, w, h, line_left, frame_left, frames_after;
    n = eff_limit(cfg_blur, BLUR_MAX);
    w = eff_limit(cfg_width, MAX_W);
    h = eff_limit(cfg_height, MAX_H);
    line_left = (column_pos + 1 >= w) ? 1 : w - column_pos;
    frame_left = (row_pos + 1 >= h) ? line_left : line_left + (h - 1 - row_pos) * w;
    frames_after = (group_phase + 1 >= n) ? 0 : n - 1 - group_phase;
    return frame_left + frames_after * w * h;
  endfunction

  task automatic queue_pixel(int r, int g, int b);
    pixel_queue.push_back('{red: CHAN_W'(r), green: CHAN_W'(g), blue: CHAN_W'(b)});
    queued_count++;
  endtask

  task automatic queue_random(int count);
    repeat (count) queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
  endtask

  task automatic settle();
    while (accepted_count != queued_count || averaged_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Growing the frame is only safe at the start of a group: the sum entries outside the
  // old frame were never written. Finish the group under the old settings first.
  task automatic set_config(int b, int w, int h);
    bit grows, at_start;
    grows = eff_limit(w & 11'h7FF, MAX_W) > eff_limit(cfg_width, MAX_W) ||
            eff_limit(h & 11'h7FF, MAX_H) > eff_limit(cfg_height, MAX_H);
    at_start = (group_phase == 0 && column_pos == 0 && row_pos == 0);
    if (grows && !at_start) begin
      queue_random(pixels_to_group_end());
      settle();
    end
    program_reg(REG_BLUR, b);
    program_reg(REG_WIDTH, w);
    program_reg(REG_HEIGHT, h);
  endtask

  initial begin : stimulus
    int kind, b, w, h, count;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reg(REG_BLUR);
    check_reg(REG_WIDTH);
    check_reg(REG_HEIGHT);

    // reset settings: every pixel is its own output
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(8'hA5, 8'h5A, 8'h3C);
    settle();

    // zero registers act as one; shrinking mid-line ends the frame at once
    set_config(0, 0, 0);
    queue_random(2);
    settle();

    // oversized blur acts as 64, then cut short mid-group so the sum saturates
    set_config(127, 1, 1);
    queue_pixel(255, 128, 1);
    settle();
    set_config(1, 1, 1);
    queue_pixel(255, 255, 255);
    settle();

    // group of four cut to two while on the third frame
    set_config(4, 2, 2);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 0);
    queue_random(7);
    settle();
    set_config(2, 2, 2);
    queue_pixel(255, 255, 255);
    queue_random(2);
    settle();

    // long receiver hold-off so both queues fill and push stalls
    set_config(1, 4, 4);
    hold_request = 1'b1;
    queue_random(64);
    settle();

    while (queued_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        b = 1;
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 1);
      end else if (kind < 16) begin
        b = 1;
        w = $urandom_range(0, 1);
        h = $urandom_range(0, 2047);
      end else if (kind < 26) begin
        case ($urandom_range(0, 2))
          0:       b = BLUR_MAX;
          1:       b = $urandom_range(65, 127);
          default: b = $urandom_range(9, 127);
        endcase
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 2);
      end else begin
        b = $urandom_range(0, 8);
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 6);
      end
      set_config(b, w, h);
      if ($urandom_range(0, 1))
        count = pixels_to_group_end();
      else
        count = (kind < 16) ? $urandom_range(20, 300) : $urandom_range(1, 40);
      queue_random(count);
      settle();
    end

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

endmodule
